// ===== rtl/delimited_field_extractor_top_defines.svh =====
// Assertion macros shared by the field extractor RTL.
`ifndef DELIMITED_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define DELIMITED_FIELD_EXTRACTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DFE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfe check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define DFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfe check failed: next-cycle implication");

`endif

// ===== rtl/dfe_pkg.sv =====
// Shared types and constants for the delimited field extractor.
package dfe_pkg;

  localparam int FIELD_COUNT_BITS = 16;
  localparam int INDEX_BITS       = 16;
  localparam int CMP_BITS         = (FIELD_COUNT_BITS > INDEX_BITS) ? FIELD_COUNT_BITS
                                                                    : INDEX_BITS;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [7:0]            DELIMITER_RESET   = 8'd44;
  localparam logic [7:0]            QUOTE_CHAR_RESET  = 8'd0;
  localparam logic [INDEX_BITS-1:0] FIELD_INDEX_RESET = INDEX_BITS'(1);

  typedef enum logic [1:0] {
    REG_DELIMITER   = 2'd0,
    REG_QUOTE_CHAR  = 2'd1,
    REG_FIELD_INDEX = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SCAN   = 3'd1,
    PH_QUOTED = 3'd2,
    PH_COPY   = 3'd3,
    PH_COPYQ  = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0]            delimiter;
    logic [7:0]            quote_char;
    logic [INDEX_BITS-1:0] field_index;
  } cfg_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       field_end;
    logic       field_found;
  } result_t;

  typedef struct packed {
    phase_t                      phase;
    logic [FIELD_COUNT_BITS-1:0] fields_passed;
  } front_status_t;

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [Q_CNT_BITS-1:0] count;
  } queue_status_t;

endpackage

// ===== rtl/dfe_front.sv =====
// Front end: per-byte line parser that classifies each beat and emits results.
module dfe_front (
  input  logic                   clk,
  input  logic                   rst,
  input  dfe_pkg::cfg_t          cfg,
  input  logic                   accept,
  input  logic [7:0]             in_char,
  output logic                   push,
  output dfe_pkg::result_t       result,
  output dfe_pkg::front_status_t status
);

  dfe_pkg::phase_t                      phase;
  dfe_pkg::phase_t                      phase_next;
  logic [dfe_pkg::FIELD_COUNT_BITS-1:0] fields_passed;
  logic [dfe_pkg::FIELD_COUNT_BITS-1:0] fields_passed_next;
  logic [dfe_pkg::FIELD_COUNT_BITS-1:0] fields_inc;

  logic                           blank;
  logic                           brk;
  logic                           eol;
  logic                           is_delim;
  logic                           is_quote;
  logic                           target;
  logic [dfe_pkg::INDEX_BITS-1:0] index_m1;

  assign blank = (cfg.delimiter == dfe_pkg::CH_TAB) || (cfg.delimiter == dfe_pkg::CH_SP);
  assign brk   = (cfg.delimiter == dfe_pkg::CH_CR) || (cfg.delimiter == dfe_pkg::CH_NL);
  assign eol   = (in_char == dfe_pkg::CH_NUL) ||
                 (!brk && ((in_char == dfe_pkg::CH_CR) || (in_char == dfe_pkg::CH_NL)));

  always_comb begin
    if (blank) begin
      is_delim = (in_char == dfe_pkg::CH_TAB) || (in_char == dfe_pkg::CH_SP);
    end else if (brk) begin
      is_delim = (in_char == dfe_pkg::CH_CR) || (in_char == dfe_pkg::CH_NL);
    end else begin
      is_delim = (in_char == cfg.delimiter);
    end
  end

  assign is_quote = (cfg.quote_char != dfe_pkg::CH_NUL) && (in_char == cfg.quote_char);
  assign index_m1 = cfg.field_index - dfe_pkg::INDEX_BITS'(1);
  assign target   = (cfg.field_index != '0) &&
                    (dfe_pkg::CMP_BITS'(fields_passed) == dfe_pkg::CMP_BITS'(index_m1));

  // saturate at the top of the counter
  assign fields_inc = (fields_passed == '1) ? fields_passed
                                            : fields_passed + dfe_pkg::FIELD_COUNT_BITS'(1);

  // next state
  always_comb begin
    phase_next         = phase;
    fields_passed_next = fields_passed;
    if (eol) begin
      phase_next         = dfe_pkg::PH_START;
      fields_passed_next = '0;
    end else begin
      unique case (phase)
        dfe_pkg::PH_START: begin
          if (blank && is_delim) begin
            phase_next = dfe_pkg::PH_START;
          end else if (target) begin
            if (is_quote) begin
              phase_next = dfe_pkg::PH_COPYQ;
            end else if (is_delim) begin
              phase_next = dfe_pkg::PH_DONE;
            end else begin
              phase_next = dfe_pkg::PH_COPY;
            end
          end else if (is_delim) begin
            fields_passed_next = fields_inc;
            phase_next         = dfe_pkg::PH_START;
          end else if (is_quote) begin
            phase_next = dfe_pkg::PH_QUOTED;
          end else begin
            phase_next = dfe_pkg::PH_SCAN;
          end
        end
        dfe_pkg::PH_SCAN: begin
          if (is_delim) begin
            fields_passed_next = fields_inc;
            phase_next         = dfe_pkg::PH_START;
          end else if (is_quote) begin
            phase_next = dfe_pkg::PH_QUOTED;
          end
        end
        dfe_pkg::PH_QUOTED: begin
          if (is_quote) begin
            phase_next = dfe_pkg::PH_SCAN;
          end
        end
        dfe_pkg::PH_COPY: begin
          if (is_delim) begin
            phase_next = dfe_pkg::PH_DONE;
          end
        end
        dfe_pkg::PH_COPYQ: begin
          if (is_quote) begin
            phase_next = dfe_pkg::PH_DONE;
          end
        end
        dfe_pkg::PH_DONE: begin
          phase_next = dfe_pkg::PH_DONE;
        end
        default: begin
          phase_next = dfe_pkg::PH_START;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    logic emit;
    emit               = 1'b0;
    result.ch          = in_char;
    result.field_end   = 1'b0;
    result.field_found = 1'b1;
    if (eol) begin
      emit               = (phase != dfe_pkg::PH_DONE);
      result.ch          = dfe_pkg::CH_NUL;
      result.field_end   = 1'b1;
      result.field_found = (phase == dfe_pkg::PH_COPY) || (phase == dfe_pkg::PH_COPYQ);
    end else begin
      unique case (phase)
        dfe_pkg::PH_START: begin
          if (!(blank && is_delim) && target && !is_quote) begin
            emit = 1'b1;
            if (is_delim) begin
              result.ch        = dfe_pkg::CH_NUL;
              result.field_end = 1'b1;
            end
          end
        end
        dfe_pkg::PH_COPY: begin
          emit = 1'b1;
          if (is_delim) begin
            result.ch        = dfe_pkg::CH_NUL;
            result.field_end = 1'b1;
          end
        end
        dfe_pkg::PH_COPYQ: begin
          emit = 1'b1;
          if (is_quote) begin
            result.ch        = dfe_pkg::CH_NUL;
            result.field_end = 1'b1;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    push = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= dfe_pkg::PH_START;
      fields_passed <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      fields_passed <= fields_passed_next;
    end
  end

  assign status.phase         = phase;
  assign status.fields_passed = fields_passed;

endmodule

// ===== rtl/dfe_queue.sv =====
// Small result queue between the parser and the output stage.
module dfe_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  dfe_pkg::result_t       push_data,
  input  logic                   pop,
  output dfe_pkg::result_t       pop_data,
  output dfe_pkg::queue_status_t status
);

  dfe_pkg::result_t                 entries [dfe_pkg::Q_DEPTH];
  logic [dfe_pkg::Q_PTR_BITS-1:0]   wr_ptr;
  logic [dfe_pkg::Q_PTR_BITS-1:0]   rd_ptr;
  logic [dfe_pkg::Q_CNT_BITS-1:0]   count;
  logic                             do_push;
  logic                             do_pop;

  assign status.full  = (count == dfe_pkg::Q_CNT_BITS'(dfe_pkg::Q_DEPTH));
  assign status.empty = (count == '0);
  assign status.count = count;

  assign do_push  = push && !status.full;
  assign do_pop   = pop && !status.empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == dfe_pkg::Q_PTR_BITS'(dfe_pkg::Q_DEPTH - 1)) ? '0
                  : wr_ptr + dfe_pkg::Q_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == dfe_pkg::Q_PTR_BITS'(dfe_pkg::Q_DEPTH - 1)) ? '0
                  : rd_ptr + dfe_pkg::Q_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + dfe_pkg::Q_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - dfe_pkg::Q_CNT_BITS'(1);
      end
    end
  end

endmodule

// ===== rtl/dfe_back.sv =====
// Back end: output register that drains the result queue onto the output channel.
module dfe_back (
  input  logic                   clk,
  input  logic                   rst,
  input  dfe_pkg::queue_status_t q_status,
  input  dfe_pkg::result_t       q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dfe_pkg::result_t       out_data
);

  // load a new beat when the register is empty or its beat leaves this cycle
  assign q_pop = !q_status.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= q_data;
    end
  end

endmodule

// ===== rtl/delimited_field_extractor_top.sv =====
// Path: a result beat enters the result queue at the accepting edge, then the output register when it has room.
// Throughput: one input beat per cycle; the parser state step is the only loop.
// The 4-entry result queue stalls input only when full (output held off).
// Reset (rst, synchronous, active high): parser at line start, field count zero,
// queue and output register empty, registers to delimiter ',', no quote, field 1.
// Top level of the delimited field extractor: APB registers, parser, queue, output.
`include "delimited_field_extractor_top_defines.svh"

module delimited_field_extractor_top (
  input  logic        clk,
  input  logic        rst,

  // input channel: one byte of line text per beat
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,

  // output channel: one field byte or one end-of-field marker per beat
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        field_end,
  output logic        field_found,

  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dfe_pkg::cfg_t          cfg;
  dfe_pkg::reg_index_t    reg_sel;
  logic                   cfg_write;

  logic                   in_accept;
  logic                   front_push;
  dfe_pkg::result_t       front_result;
  dfe_pkg::front_status_t front_status;

  logic                   q_pop;
  dfe_pkg::result_t       q_data;
  dfe_pkg::queue_status_t q_status;
  dfe_pkg::result_t       out_data;

  logic                   nul_accept;
  logic                   front_clear;

  // ------------------------------------------------------------------
  // Configuration registers: word addressed, no wait states.
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = dfe_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter   <= dfe_pkg::DELIMITER_RESET;
      cfg.quote_char  <= dfe_pkg::QUOTE_CHAR_RESET;
      cfg.field_index <= dfe_pkg::FIELD_INDEX_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        dfe_pkg::REG_DELIMITER:   cfg.delimiter   <= pwdata[7:0];
        dfe_pkg::REG_QUOTE_CHAR:  cfg.quote_char  <= pwdata[7:0];
        dfe_pkg::REG_FIELD_INDEX: cfg.field_index <= pwdata[dfe_pkg::INDEX_BITS-1:0];
        default: begin
          // drop writes to unmapped addresses
        end
      endcase
    end
  end

  // read back; unmapped addresses read as zero
  always_comb begin
    unique case (reg_sel)
      dfe_pkg::REG_DELIMITER:   prdata = 32'(cfg.delimiter);
      dfe_pkg::REG_QUOTE_CHAR:  prdata = 32'(cfg.quote_char);
      dfe_pkg::REG_FIELD_INDEX: prdata = 32'(cfg.field_index);
      default:                  prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Front: take a byte whenever the queue has room. The parser steps
  // once per accepted beat and pushes at most one result beat.
  // ------------------------------------------------------------------
  assign in_ready  = !q_status.full;
  assign in_accept = in_valid && in_ready;

  dfe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (in_accept),
    .in_char (in_char),
    .push    (front_push),
    .result  (front_result),
    .status  (front_status)
  );

  // ------------------------------------------------------------------
  // Queue: decouples the parser from output back-pressure.
  // ------------------------------------------------------------------
  dfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_result),
    .pop       (q_pop),
    .pop_data  (q_data),
    .status    (q_status)
  );

  // ------------------------------------------------------------------
  // Back: registered output stage; advance when the consumer takes a beat.
  // ------------------------------------------------------------------
  dfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_char    = out_data.ch;
  assign field_end   = out_data.field_end;
  assign field_found = out_data.field_found;

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  assign nul_accept  = in_accept && (in_char == dfe_pkg::CH_NUL);
  assign front_clear = (front_status.phase == dfe_pkg::PH_START) &&
                       (front_status.fields_passed == '0);

  // A NUL byte always ends the line: the parser restarts with a clear count.
  `DFE_ASSERT_NEXT(a_nul_restarts, clk, rst, nul_accept, front_clear)
  // The parser never pushes into a full queue.
  `DFE_ASSERT_IMPLY(a_no_overflow, clk, rst, front_push, !q_status.full)
  // A byte beat always belongs to a field that was reached.
  `DFE_ASSERT_IMPLY(a_byte_found, clk, rst, out_valid && !field_end, field_found)

endmodule

// ===== tb/sv/tb_delimited_field_extractor_top.sv =====
// Self-checking testbench for the delimited field extractor: directed table, then random lines.
module tb_delimited_field_extractor_top;

  localparam int         SETTLE_CYCLES = 6;       // output latency plus margin
  localparam int         RANDOM_BYTES  = 1700;
  localparam int         LIMIT_CYCLES  = 1000000;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;

  // One row of the directed table: either a register load or one input beat.
  typedef enum logic {ROW_BYTE, ROW_REGS} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    dfe_pkg::cfg_t     regs;
    logic [7:0]        ch;
    logic              typed;   // expected beat typed in below instead of predicted
    dfe_pkg::result_t  want;
  } dir_row_t;

  localparam dfe_pkg::result_t END_FOUND  = {dfe_pkg::CH_NUL, 1'b1, 1'b1};
  localparam dfe_pkg::result_t END_MISSED = {dfe_pkg::CH_NUL, 1'b1, 1'b0};

  function automatic dir_row_t byte_row(input logic [7:0] ch);
    dir_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.ch = ch;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input logic [7:0] ch,
                                         input dfe_pkg::result_t want);
    dir_row_t r;
    r = byte_row(ch);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t regs_row(input logic [7:0] d, input logic [7:0] q,
                                        input logic [15:0] idx);
    dir_row_t r;
    r = '0;
    r.kind = ROW_REGS;
    r.regs = {d, q, idx};
    return r;
  endfunction

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // reset registers: comma, no quoting, first field
    typed_row("a", {"a", 1'b0, 1'b1}),
    typed_row(",", END_FOUND),          // delimiter ends the target
    byte_row("q"),                      // rest of line ignored
    byte_row(dfe_pkg::CH_NL),           // line end after target ended: nothing
    typed_row(dfe_pkg::CH_NUL, END_MISSED),  // empty line
    // blanks as delimiter, quoted second field
    regs_row(dfe_pkg::CH_TAB, CH_DQUOTE, 16'd2),
    byte_row(dfe_pkg::CH_SP),           // leading blank skipped
    byte_row("x"),
    byte_row(dfe_pkg::CH_TAB),
    byte_row(dfe_pkg::CH_SP),           // run of blanks is one separator
    byte_row(CH_DQUOTE),                // opens the quoted target
    byte_row(dfe_pkg::CH_SP),           // blank copied inside quotes
    byte_row(CH_DQUOTE),                // closing quote ends the field
    byte_row(dfe_pkg::CH_CR),
    // line breaks as delimiter, field zero, quote at the top byte
    regs_row(dfe_pkg::CH_NL, 8'hFF, 16'd0),
    byte_row(dfe_pkg::CH_CR),           // separator, not a line end
    byte_row(8'hFF),                    // opens a quoted span while scanning
    typed_row(dfe_pkg::CH_NUL, END_MISSED),  // field zero is never reached
    // delimiter equal to quote
    regs_row(";", ";", 16'd3),
    byte_row(";"),
    byte_row(";"),
    byte_row(";"),                      // at the target it opens a quoted field
    byte_row(8'h80),
    typed_row(dfe_pkg::CH_CR, END_FOUND)     // line end inside the target
  };

  // DUT inputs start at known values
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_char   = '0;
  logic        out_ready = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;

  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        field_end;
  logic        field_found;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: a copy of the registers and of the line scan.
  dfe_pkg::cfg_t   cfg_shadow = {dfe_pkg::DELIMITER_RESET, dfe_pkg::QUOTE_CHAR_RESET,
                                 dfe_pkg::FIELD_INDEX_RESET};
  dfe_pkg::phase_t scan_phase = dfe_pkg::PH_START;
  logic [dfe_pkg::FIELD_COUNT_BITS-1:0] sep_count = '0;

  dfe_pkg::result_t field_beats_due[$];   // expected output beats, oldest first
  int      fail_count  = 0;
  int      bytes_sent  = 0;
  bit      quiet_mode  = 1'b0;   // no random idling on either side while set; a requested long hold-off still applies
  int      long_stall_len = 0;   // request for a long receiver hold-off
  int      stall_left  = 0;
  int      ready_left  = 0;
  bit      ready_high  = 1'b0;

  delimited_field_extractor_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char    (in_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .field_end  (field_end),
    .field_found(field_found),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk = ~clk;

  // Advance the line scan by one byte; return 1 when the byte yields an output beat.
  function automatic bit extract_step(input logic [7:0] c, output dfe_pkg::result_t beat);
    logic            blank_mode;
    logic            break_mode;
    logic            line_end;
    logic            is_sep;
    logic            is_quote;
    dfe_pkg::phase_t was;
    blank_mode = (cfg_shadow.delimiter == dfe_pkg::CH_TAB) ||
                 (cfg_shadow.delimiter == dfe_pkg::CH_SP);
    break_mode = (cfg_shadow.delimiter == dfe_pkg::CH_CR) ||
                 (cfg_shadow.delimiter == dfe_pkg::CH_NL);
    line_end   = (c == dfe_pkg::CH_NUL) ||
                 (!break_mode && (c == dfe_pkg::CH_CR || c == dfe_pkg::CH_NL));
    is_quote   = (cfg_shadow.quote_char != dfe_pkg::CH_NUL) && (c == cfg_shadow.quote_char);
    if (blank_mode) is_sep = (c == dfe_pkg::CH_TAB) || (c == dfe_pkg::CH_SP);
    else if (break_mode) is_sep = (c == dfe_pkg::CH_CR) || (c == dfe_pkg::CH_NL);
    else is_sep = (c == cfg_shadow.delimiter);
    beat = END_FOUND;

    if (line_end) begin
      was = scan_phase;
      scan_phase = dfe_pkg::PH_START;
      sep_count = '0;
      if (was == dfe_pkg::PH_DONE) return 1'b0;
      beat.field_found = (was == dfe_pkg::PH_COPY) || (was == dfe_pkg::PH_COPYQ);
      return 1'b1;
    end

    if (scan_phase == dfe_pkg::PH_START) begin
      if (blank_mode && is_sep) return 1'b0;
      if (cfg_shadow.field_index != '0 &&
          sep_count == cfg_shadow.field_index - 16'd1) begin
        if (is_quote) begin
          scan_phase = dfe_pkg::PH_COPYQ;
          return 1'b0;
        end
        if (is_sep) begin
          scan_phase = dfe_pkg::PH_DONE;
          return 1'b1;
        end
        scan_phase = dfe_pkg::PH_COPY;
        beat.ch = c;
        beat.field_end = 1'b0;
        return 1'b1;
      end
      // not the target: scan this same byte as part of a skipped field
      scan_phase = dfe_pkg::PH_SCAN;
    end

    case (scan_phase)
      dfe_pkg::PH_SCAN: begin
        if (is_sep) begin
          if (sep_count != '1) sep_count = sep_count + dfe_pkg::FIELD_COUNT_BITS'(1);
          scan_phase = dfe_pkg::PH_START;
        end else if (is_quote) begin
          scan_phase = dfe_pkg::PH_QUOTED;
        end
        return 1'b0;
      end
      dfe_pkg::PH_QUOTED: begin
        if (is_quote) scan_phase = dfe_pkg::PH_SCAN;
        return 1'b0;
      end
      dfe_pkg::PH_COPY, dfe_pkg::PH_COPYQ: begin
        if (scan_phase == dfe_pkg::PH_COPY ? is_sep : is_quote) begin
          scan_phase = dfe_pkg::PH_DONE;
          return 1'b1;
        end
        beat.ch = c;
        beat.field_end = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Idle length: mostly none, sometimes a short gap, rarely a long gap.
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Compare one output beat against the oldest expectation.
  function automatic void check_field_beat();
    dfe_pkg::result_t want;
    if (field_beats_due.size() == 0) begin
      $display("%0t: unexpected beat: expected none, actual char %h end %b found %b",
               $time, out_char, field_end, field_found);
      fail_count++;
      return;
    end
    want = field_beats_due.pop_front();
    if (out_char !== want.ch) begin
      $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
      fail_count++;
    end
    if (field_end !== want.field_end) begin
      $display("%0t: field_end expected %b actual %b", $time, want.field_end, field_end);
      fail_count++;
    end
    if (field_found !== want.field_found) begin
      $display("%0t: field_found expected %b actual %b", $time, want.field_found,
               field_found);
      fail_count++;
    end
  endfunction

  // Receiver: check accepted beats, then choose out_ready for the next edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_field_beat();
    if (long_stall_len != 0) begin
      stall_left = long_stall_len;
      long_stall_len = 0;
    end
    if (stall_left > 0) begin
      // hold off for the whole stretch so the result queue fills up
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      if (ready_left == 0) begin
        ready_high = quiet_mode || ($urandom_range(0, 2) != 0);
        ready_left = ready_high ? $urandom_range(1, 20) : 1 + pick_gap();
      end
      ready_left--;
      out_ready <= ready_high;
    end
  end

  // Offer one byte, hold it until accepted, then record what it should produce.
  task automatic send_byte(input logic [7:0] ch, input logic typed = 1'b0,
                           input dfe_pkg::result_t want = '0);
    int               gap;
    bit               has_beat;
    dfe_pkg::result_t beat;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= ch;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    has_beat = extract_step(ch, beat);
    if (typed) field_beats_due.push_back(want);
    else if (has_beat) field_beats_due.push_back(beat);
  endtask

  // Drop the input, wait for every expected beat, then let the pipeline empty.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (field_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input dfe_pkg::reg_index_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_registers(input dfe_pkg::cfg_t c);
    write_reg(dfe_pkg::REG_DELIMITER,   32'(c.delimiter));
    write_reg(dfe_pkg::REG_QUOTE_CHAR,  32'(c.quote_char));
    write_reg(dfe_pkg::REG_FIELD_INDEX, 32'(c.field_index));
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_shadow = c;
  endtask

  // Register settings per random phase; the first two hit the extremes, the third uses blanks with quoting.
  function automatic dfe_pkg::cfg_t pick_registers(input int phase_no);
    dfe_pkg::cfg_t c;
    int            r;
    case (phase_no)
      0: return {8'h00, 8'hFF, 16'hFFFF};
      1: return {8'hFF, 8'h00, 16'h0000};
      2: return {dfe_pkg::CH_SP, CH_DQUOTE, 16'd1};
      default: ;
    endcase
    r = $urandom_range(0, 9);
    if (r < 3) c.delimiter = ",";
    else if (r == 3) c.delimiter = dfe_pkg::CH_SP;
    else if (r == 4) c.delimiter = dfe_pkg::CH_TAB;
    else if (r == 5) c.delimiter = dfe_pkg::CH_CR;
    else if (r == 6) c.delimiter = dfe_pkg::CH_NL;
    else if (r == 7) c.delimiter = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    else c.delimiter = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    if (r < 4) c.quote_char = CH_DQUOTE;
    else if (r == 4) c.quote_char = dfe_pkg::CH_NUL;
    else if (r == 5) c.quote_char = c.delimiter;
    else if (r == 6) c.quote_char = 8'hFF;
    else c.quote_char = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    if (r == 0) c.field_index = '0;
    else if (r < 8) c.field_index = 16'($urandom_range(1, 4));
    else if (r == 8) c.field_index = '1;
    else c.field_index = 16'($urandom_range(0, 65535));
    return c;
  endfunction

  // Field content: mostly letters, with quotes, blanks and arbitrary bytes mixed in.
  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return 8'($urandom_range(97, 122));
    if (r < 15 && cfg_shadow.quote_char != dfe_pkg::CH_NUL) return cfg_shadow.quote_char;
    if (r < 17) return dfe_pkg::CH_SP;
    if (r == 17) return dfe_pkg::CH_TAB;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? dfe_pkg::CH_SP : dfe_pkg::CH_TAB;
  endfunction

  // One line: mostly well-formed fields with random content, some noise and
  // some lines left without their end so they run into the next one.
  task automatic emit_line();
    int   nfields;
    int   len;
    logic blank_mode;
    logic break_mode;
    blank_mode = (cfg_shadow.delimiter == dfe_pkg::CH_TAB) ||
                 (cfg_shadow.delimiter == dfe_pkg::CH_SP);
    break_mode = (cfg_shadow.delimiter == dfe_pkg::CH_CR) ||
                 (cfg_shadow.delimiter == dfe_pkg::CH_NL);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      if (blank_mode && $urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) send_byte(pick_blank());
      nfields = $urandom_range(0, 6);
      for (int f = 0; f < nfields; f++) begin
        if (f > 0) begin
          if (blank_mode) repeat ($urandom_range(1, 3)) send_byte(pick_blank());
          else if (break_mode) send_byte($urandom_range(0, 1) ? dfe_pkg::CH_CR
                                                              : dfe_pkg::CH_NL);
          else send_byte(cfg_shadow.delimiter);
        end
        len = $urandom_range(0, 5);
        if (cfg_shadow.quote_char != dfe_pkg::CH_NUL && $urandom_range(0, 3) == 0) begin
          send_byte(cfg_shadow.quote_char);
          repeat (len) send_byte(text_byte());
          // leave a quote open now and then
          if ($urandom_range(0, 7) != 0) send_byte(cfg_shadow.quote_char);
        end else begin
          repeat (len) send_byte(text_byte());
        end
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      if (break_mode) send_byte(dfe_pkg::CH_NUL);
      else case ($urandom_range(0, 2))
        0:       send_byte(dfe_pkg::CH_NUL);
        1:       send_byte(dfe_pkg::CH_CR);
        default: send_byte(dfe_pkg::CH_NL);
      endcase
    end
  endtask

  task automatic run_random_phase(input int phase_no);
    int quota;
    settle_idle();
    load_registers(pick_registers(phase_no));
    quiet_mode = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 6) == 0) long_stall_len = $urandom_range(40, 150);
    quota = bytes_sent + $urandom_range(30, 90);
    while (bytes_sent < quota) emit_line();
  endtask

  initial begin
    int random_start;
    int phase_no;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; register loads wait for the block to go idle.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_REGS) begin
        settle_idle();
        load_registers(DIRECTED[i].regs);
      end else begin
        send_byte(DIRECTED[i].ch, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // Pressure: every byte of a long first field is copied while the receiver
    // holds off, so the result queue fills and the input stalls.
    settle_idle();
    load_registers({8'(","), dfe_pkg::CH_NUL, 16'd1});
    quiet_mode = 1'b1;
    long_stall_len = 150;
    repeat (32) send_byte(8'($urandom_range(97, 122)));
    send_byte(dfe_pkg::CH_NUL);
    quiet_mode = 1'b0;

    random_start = bytes_sent;
    phase_no = 0;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      run_random_phase(phase_no);
      phase_no++;
    end

    settle_idle();
    if (fail_count == 0 && field_beats_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(20 * LIMIT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dfe_pkg.sv
rtl/dfe_front.sv
rtl/dfe_queue.sv
rtl/dfe_back.sv
rtl/delimited_field_extractor_top.sv
tb/sv/tb_delimited_field_extractor_top.sv
